FILE: sv/owbm_pkg.sv
// Package for the single-wire bus master: field widths, register indexes,
// phase codes and the shared structs. No dependencies.
package owbm_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TIMER_WIDTH_DEF = 10;
    localparam int BIT_IDX_W  = $clog2(BYTE_BITS);

    // Stream packing widths
    localparam int S_TDATA_W = 16;   // tx_byte, line_in, zero fill
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 16;   // drive_low .. reset_status, zero fill

    // Commands carried on s_tuser
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_XFER  = 2'd2;

    // Reset outcome codes
    localparam logic [STATUS_W-1:0] STAT_PRESENT  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STUCK    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_REL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DLY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TAIL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_LIMIT  = 3'd6;

    // Bus phases, one-hot
    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_WAIT  = 8'b0000_0010,
        PH_RLOW  = 8'b0000_0100,
        PH_RREL  = 8'b0000_1000,
        PH_RTAIL = 8'b0001_0000,
        PH_SLOW  = 8'b0010_0000,
        PH_SMID  = 8'b0100_0000,
        PH_STAIL = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] presence_sample_us;
        logic [9:0] reset_tail_us;
        logic [3:0] slot_release_us;
        logic [5:0] sample_delay_us;
        logic [6:0] slot_tail_us;
        logic [7:0] wait_high_limit;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  reset_status;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 done_res;
        logic                 busy_res;
        logic                 drive_low;
    } result_t;

endpackage

FILE: sv/owbm_cfg.sv
// Configuration register file for the single-wire bus master.
// Depends on owbm_pkg for register indexes and the cfg_t struct.
module owbm_cfg import owbm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Load one register per write, truncated to its width; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us       <= 10'd480;
            cfg_reg.presence_sample_us <= 8'd66;
            cfg_reg.reset_tail_us      <= 10'd414;
            cfg_reg.slot_release_us    <= 4'd1;
            cfg_reg.sample_delay_us    <= 6'd14;
            cfg_reg.slot_tail_us       <= 7'd45;
            cfg_reg.wait_high_limit    <= 8'd128;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RESET_LOW:   cfg_reg.reset_low_us       <= cfg_wdata[9:0];
                REG_PRES_SAMPLE: cfg_reg.presence_sample_us <= cfg_wdata[7:0];
                REG_RESET_TAIL:  cfg_reg.reset_tail_us      <= cfg_wdata[9:0];
                REG_SLOT_REL:    cfg_reg.slot_release_us    <= cfg_wdata[3:0];
                REG_SAMPLE_DLY:  cfg_reg.sample_delay_us    <= cfg_wdata[5:0];
                REG_SLOT_TAIL:   cfg_reg.slot_tail_us       <= cfg_wdata[6:0];
                REG_WAIT_LIMIT:  cfg_reg.wait_high_limit    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/owbm_core.sv
// Bus sequencer: phase, tick timer, slot counter and shift register, one
// update per accepted tick beat. Depends on owbm_pkg.
module owbm_core import owbm_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [FUNC_W-1:0]    func,
    input  logic [BYTE_BITS-1:0] tx_byte,
    input  logic                 line_in,
    input  cfg_t                 cfg,
    output result_t              result
);

    localparam logic [16:0] TMAX = 17'((1 << TIMER_WIDTH) - 1);

    phase_t                 phase_reg,   phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg,   timer_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [BYTE_BITS-1:0]   shift_reg,   shift_next;
    logic                   cur_bit_reg, cur_bit_next;
    logic [STATUS_W-1:0]    status_reg,  status_next;
    logic                   done;
    logic [TIMER_WIDTH-1:0] d_rlow, d_rrel, d_rtail, d_slow, d_smid, d_stail;
    logic [TIMER_WIDTH-1:0] limit;

    // Clamp a duration to at least one tick and at most the timer range
    function automatic logic [TIMER_WIDTH-1:0] sat_dur(input logic [CFG_DATA_W-1:0] d);
        logic [16:0] d_ext;
        d_ext = 17'(d);
        if (d_ext == 17'd0) begin
            sat_dur = TIMER_WIDTH'(1);
        end else if (d_ext > TMAX) begin
            sat_dur = TMAX[TIMER_WIDTH-1:0];
        end else begin
            sat_dur = d_ext[TIMER_WIDTH-1:0];
        end
    endfunction

    assign d_rlow  = sat_dur(cfg.reset_low_us);
    assign d_rrel  = sat_dur(CFG_DATA_W'(cfg.presence_sample_us));
    assign d_rtail = sat_dur(cfg.reset_tail_us);
    assign d_slow  = sat_dur(CFG_DATA_W'(cfg.slot_release_us));
    assign d_smid  = sat_dur(CFG_DATA_W'(cfg.sample_delay_us));
    assign d_stail = sat_dur(CFG_DATA_W'(cfg.slot_tail_us));
    assign limit   = TIMER_WIDTH'(cfg.wait_high_limit);

    // Next state for one tick: command start, timer countdown, line wait
    always_comb begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        cur_bit_next = cur_bit_reg;
        status_next  = status_reg;
        done         = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (func == FUNC_RESET) begin
                phase_next = PH_WAIT;
                timer_next = '0;
            end else if (func == FUNC_XFER) begin
                shift_next   = tx_byte;
                bit_idx_next = '0;
                cur_bit_next = tx_byte[0];
                phase_next   = PH_SLOW;
                timer_next   = d_slow;
            end
        end else if (phase_reg != PH_WAIT) begin
            if (timer_reg > TIMER_WIDTH'(1)) begin
                timer_next = timer_reg - TIMER_WIDTH'(1);
            end else begin
                case (phase_reg)
                    PH_RLOW: begin
                        phase_next = PH_RREL;
                        timer_next = d_rrel;
                    end
                    PH_RREL: begin
                        status_next = line_in ? STAT_ABSENT : STAT_PRESENT;
                        phase_next  = PH_RTAIL;
                        timer_next  = d_rtail;
                    end
                    PH_RTAIL: begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        done       = 1'b1;
                    end
                    PH_SLOW: begin
                        phase_next = PH_SMID;
                        timer_next = d_smid;
                    end
                    PH_SMID: begin
                        shift_next = {line_in, shift_reg[BYTE_BITS-1:1]};
                        phase_next = PH_STAIL;
                        timer_next = d_stail;
                    end
                    PH_STAIL: begin
                        if (bit_idx_reg == BIT_IDX_W'(BYTE_BITS - 1)) begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                            done       = 1'b1;
                        end else begin
                            bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                            cur_bit_next = shift_reg[0];
                            phase_next   = PH_SLOW;
                            timer_next   = d_slow;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // Wait for the line to float high before a reset pulse
        if (phase_next == PH_WAIT) begin
            if (line_in) begin
                phase_next = PH_RLOW;
                timer_next = d_rlow;
            end else begin
                timer_next = timer_next + TIMER_WIDTH'(1);
                if (timer_next >= limit) begin
                    status_next = STAT_STUCK;
                    phase_next  = PH_IDLE;
                    timer_next  = '0;
                    done        = 1'b1;
                end
            end
        end
    end

    // Line drive seen after this tick's update
    always_comb begin
        result.drive_low = 1'b0;
        case (phase_next)
            PH_RLOW, PH_SLOW: result.drive_low = 1'b1;
            PH_SMID:          result.drive_low = !cur_bit_next;
            PH_STAIL:         result.drive_low = !cur_bit_next && (timer_next > TIMER_WIDTH'(1));
            default:          result.drive_low = 1'b0;
        endcase
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done;
        result.rx_byte      = shift_next;
        result.reset_status = status_next;
    end

    // Advance state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            cur_bit_reg <= 1'b0;
            status_reg  <= STAT_PRESENT;
        end else if (step) begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            cur_bit_reg <= cur_bit_next;
            status_reg  <= status_next;
        end
    end

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("phase register lost its one-hot code");

    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (timer_reg == '0))
        else $error("timer not cleared in idle");

    a_timed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE && phase_reg != PH_WAIT) |-> (timer_reg != '0))
        else $error("timed phase with empty timer");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> (phase_reg == PH_IDLE))
        else $error("completion without return to idle");

endmodule

FILE: sv/owbm_out.sv
// Result register between the sequencer and the master stream side.
// Depends on owbm_pkg for result_t.
module owbm_out import owbm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_data
);

    logic    valid_reg;
    result_t data_reg;

    // Take a new beat whenever the held one is gone or leaving
    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

endmodule

FILE: sv/one_wire_bus_master.sv
// Single-wire bus master top level: stream ports, configuration port.
// Instantiates owbm_cfg, owbm_core and owbm_out; depends on owbm_pkg.
//
// Usage: each s_ beat is one microsecond tick. s_tuser carries the command
// (plain tick, start reset, start byte transfer); s_tdata carries the byte
// to send and the sampled line level. Every tick beat yields exactly one
// m_ beat with the line drive, busy, done, received byte and reset status
// as they stand after that tick. Commands while busy are ignored.
// Output: the result of a tick is registered and appears on m_ in the cycle after acceptance.
// Throughput: one tick per cycle; the sequencer state updates in the same
// cycle the beat is taken, and a single output register holds the result.
// s_tready is low only while a result waits and m_tready is low.
// Configuration: cfg_we writes register cfg_index with cfg_wdata at the
// clock edge; write only while no operation runs.
// Reset: aresetn (synchronous, low) returns the block to idle with default
// timings, clears the received byte and status, and empties the output.
module one_wire_bus_master import owbm_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] tx_byte, [8] line_in
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] rx_byte, [12:11] reset_status
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int RES_W = $bits(result_t);

    cfg_t    cfg;
    result_t core_res;
    result_t out_res;
    logic    step;

    owbm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign step = s_tvalid && s_tready;

    owbm_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .func    (s_tuser[FUNC_W-1:0]),
        .tx_byte (s_tdata[BYTE_BITS-1:0]),
        .line_in (s_tdata[BYTE_BITS]),
        .cfg     (cfg),
        .result  (core_res)
    );

    owbm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (core_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_data   (out_res)
    );

    assign m_tdata = {{(M_TDATA_W - RES_W){1'b0}}, out_res};

    a_beat_yields_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("accepted tick produced no result beat");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[1])
        else $error("result shows done while still busy");

    a_idle_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[1]) |-> !m_tdata[0])
        else $error("line driven low while idle");

endmodule

FILE: verif/owbm_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the single-wire bus master testbench: a tick-level model of
// the bus sequencer and a queue of expected result beats. Depends on owbm_pkg.
package owbm_scoreboard_pkg;
    import owbm_pkg::*;

    localparam int TICK_MAX = (1 << TIMER_WIDTH_DEF) - 1;

    class owbm_scoreboard;
        cfg_t                 timing;
        phase_t               ph;
        logic [9:0]           tmr;
        logic [2:0]           bit_idx;
        logic [7:0]           shreg;
        logic                 cur_bit;
        logic [STATUS_W-1:0]  status;
        result_t              expected_bus_q[$];
        int                   n_fail;

        function new();
            timing.reset_low_us       = 10'd480;
            timing.presence_sample_us = 8'd66;
            timing.reset_tail_us      = 10'd414;
            timing.slot_release_us    = 4'd1;
            timing.sample_delay_us    = 6'd14;
            timing.slot_tail_us       = 7'd45;
            timing.wait_high_limit    = 8'd128;
            ph      = PH_IDLE;
            tmr     = '0;
            bit_idx = '0;
            shreg   = '0;
            cur_bit = 1'b0;
            status  = STAT_PRESENT;
            n_fail  = 0;
        endfunction

        function phase_t phase_now();
            return ph;
        endfunction

        function int pending();
            return expected_bus_q.size();
        endfunction

        // Mirror a register write, truncated to the register's width
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_RESET_LOW:   timing.reset_low_us       = val[9:0];
                REG_PRES_SAMPLE: timing.presence_sample_us = val[7:0];
                REG_RESET_TAIL:  timing.reset_tail_us      = val[9:0];
                REG_SLOT_REL:    timing.slot_release_us    = val[3:0];
                REG_SAMPLE_DLY:  timing.sample_delay_us    = val[5:0];
                REG_SLOT_TAIL:   timing.slot_tail_us       = val[6:0];
                REG_WAIT_LIMIT:  timing.wait_high_limit    = val[7:0];
                default: ;
            endcase
        endfunction

        // Enter a timed phase; zero counts as one tick, long ones saturate
        function void start_phase(phase_t nxt, int unsigned dur);
            if (dur < 1) dur = 1;
            if (dur > TICK_MAX) dur = TICK_MAX;
            ph  = nxt;
            tmr = dur[9:0];
        endfunction

        // Advance the sequencer by one tick and queue the resulting bus state
        function void advance_bus(logic [FUNC_W-1:0] func, logic [7:0] tx, logic line);
            logic    fin;
            result_t r;
            fin = 1'b0;
            if (ph == PH_IDLE) begin
                if (func == FUNC_RESET) begin
                    ph  = PH_WAIT;
                    tmr = '0;
                end else if (func == FUNC_XFER) begin
                    shreg   = tx;
                    bit_idx = '0;
                    cur_bit = tx[0];
                    start_phase(PH_SLOW, timing.slot_release_us);
                end
            end else if (ph != PH_WAIT) begin
                if (tmr > 1) begin
                    tmr = tmr - 1'b1;
                end else begin
                    case (ph)
                        PH_RLOW: start_phase(PH_RREL, timing.presence_sample_us);
                        PH_RREL: begin
                            status = line ? STAT_ABSENT : STAT_PRESENT;
                            start_phase(PH_RTAIL, timing.reset_tail_us);
                        end
                        PH_RTAIL: begin
                            ph  = PH_IDLE;
                            tmr = '0;
                            fin = 1'b1;
                        end
                        PH_SLOW: start_phase(PH_SMID, timing.sample_delay_us);
                        PH_SMID: begin
                            shreg = {line, shreg[7:1]};
                            start_phase(PH_STAIL, timing.slot_tail_us);
                        end
                        PH_STAIL: begin
                            if (bit_idx == 3'(BYTE_BITS - 1)) begin
                                ph  = PH_IDLE;
                                tmr = '0;
                                fin = 1'b1;
                            end else begin
                                bit_idx = bit_idx + 1'b1;
                                cur_bit = shreg[0];
                                start_phase(PH_SLOW, timing.slot_release_us);
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Wait for a high line; count low samples toward a stuck bus
            if (ph == PH_WAIT) begin
                if (line) begin
                    start_phase(PH_RLOW, timing.reset_low_us);
                end else begin
                    tmr = tmr + 1'b1;
                    if (tmr >= {2'b00, timing.wait_high_limit}) begin
                        status = STAT_STUCK;
                        ph     = PH_IDLE;
                        tmr    = '0;
                        fin    = 1'b1;
                    end
                end
            end

            case (ph)
                PH_RLOW, PH_SLOW: r.drive_low = 1'b1;
                PH_SMID:          r.drive_low = !cur_bit;
                PH_STAIL:         r.drive_low = !cur_bit && (tmr > 1);
                default:          r.drive_low = 1'b0;
            endcase
            r.busy_res     = (ph != PH_IDLE);
            r.done_res     = fin;
            r.rx_byte      = shreg;
            r.reset_status = status;
            expected_bus_q.push_back(r);
        endfunction

        function void note_tick(logic [S_TDATA_W-1:0] data, logic [S_TUSER_W-1:0] user);
            advance_bus(user, data[7:0], data[8]);
        endfunction

        // Compare one result beat against the oldest expected bus state
        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t got;
            result_t exp_r;
            got = result_t'(data[$bits(result_t)-1:0]);
            if (expected_bus_q.size() == 0) begin
                $error("result beat with nothing expected: %h", data);
                n_fail++;
                return;
            end
            exp_r = expected_bus_q.pop_front();
            if (got.drive_low !== exp_r.drive_low) begin
                $error("drive_low: expected %0d, got %0d", exp_r.drive_low, got.drive_low);
                n_fail++;
            end
            if (got.busy_res !== exp_r.busy_res) begin
                $error("busy_res: expected %0d, got %0d", exp_r.busy_res, got.busy_res);
                n_fail++;
            end
            if (got.done_res !== exp_r.done_res) begin
                $error("done_res: expected %0d, got %0d", exp_r.done_res, got.done_res);
                n_fail++;
            end
            if (got.rx_byte !== exp_r.rx_byte) begin
                $error("rx_byte: expected %h, got %h", exp_r.rx_byte, got.rx_byte);
                n_fail++;
            end
            if (got.reset_status !== exp_r.reset_status) begin
                $error("reset_status: expected %0d, got %0d",
                       exp_r.reset_status, got.reset_status);
                n_fail++;
            end
        endfunction
    endclass

endpackage

FILE: verif/tb_one_wire_bus_master.sv
`timescale 1ns / 1ps
// Testbench top for one_wire_bus_master: drives tick beats with bus-level
// patterns, stalls both sides, and checks every result beat against the
// scoreboard model. Depends on owbm_pkg and owbm_scoreboard_pkg.
module tb_one_wire_bus_master;
    import owbm_pkg::*;
    import owbm_scoreboard_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_TICKS  = 60;
    localparam int RAND_PHASES  = 6;

    typedef enum logic [1:0] {LN_RAND, LN_HIGH, LN_LOW, LN_ANSWER} line_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    owbm_scoreboard sb = new();
    bit gaps_on = 1'b1;
    int ticks_sent = 0;
    int idle_cycles = 0;

    one_wire_bus_master u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Track accepted beats on both sides; stop on a hung handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_tick(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("one_wire_bus_master regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: ready with random stall bursts while gaps are enabled
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 13) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic pick_line(line_mode_t mode);
        phase_t p;
        p = sb.phase_now();
        case (mode)
            LN_HIGH:   return 1'b1;
            LN_LOW:    return 1'b0;
            // slave pulls low after the reset pulse so presence is seen
            LN_ANSWER: return !(p == PH_RLOW || p == PH_RREL);
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Send one tick beat, with an optional idle burst in front of it
    task automatic send_tick(logic [FUNC_W-1:0] func, logic [7:0] tx, logic line);
        if (gaps_on && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, line, tx};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    // Issue a command and keep ticking until the sequencer is idle again
    task automatic run_op(logic [FUNC_W-1:0] func, logic [7:0] tx, line_mode_t mode,
                          logic [FUNC_W-1:0] busy_func);
        send_tick(func, tx, pick_line(mode));
        while (sb.phase_now() != PH_IDLE)
            send_tick(busy_func, 8'($urandom_range(0, 255)), pick_line(mode));
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic load_timing(cfg_t c);
        drain_results();
        write_reg(REG_RESET_LOW,   CFG_DATA_W'(c.reset_low_us));
        write_reg(REG_PRES_SAMPLE, CFG_DATA_W'(c.presence_sample_us));
        write_reg(REG_RESET_TAIL,  CFG_DATA_W'(c.reset_tail_us));
        write_reg(REG_SLOT_REL,    CFG_DATA_W'(c.slot_release_us));
        write_reg(REG_SAMPLE_DLY,  CFG_DATA_W'(c.sample_delay_us));
        write_reg(REG_SLOT_TAIL,   CFG_DATA_W'(c.slot_tail_us));
        write_reg(REG_WAIT_LIMIT,  CFG_DATA_W'(c.wait_high_limit));
        cfg_we <= 1'b0;
    endtask

    // Short timings keep operations brief so many fit in a phase
    function automatic cfg_t short_timing();
        cfg_t c;
        c.reset_low_us       = 10'($urandom_range(0, 6));
        c.presence_sample_us = 8'($urandom_range(0, 4));
        c.reset_tail_us      = 10'($urandom_range(0, 6));
        c.slot_release_us    = 4'($urandom_range(0, 3));
        c.sample_delay_us    = 6'($urandom_range(0, 4));
        c.slot_tail_us       = 7'($urandom_range(0, 5));
        c.wait_high_limit    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 8));
        return c;
    endfunction

    initial begin
        cfg_t       c;
        int         start_ticks;
        int         pick;
        line_mode_t mode;
        logic [FUNC_W-1:0] busy;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_TICK;
        cfg_we    = 1'b0;
        cfg_index = REG_RESET_LOW;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Power-on timings: one transfer and one reset on a bus stuck low
        run_op(FUNC_XFER, 8'h5A, LN_RAND, FUNC_TICK);
        run_op(FUNC_RESET, 8'h00, LN_LOW, FUNC_XFER);

        // Shortest timings, zero wait limit
        c = '0;
        load_timing(c);
        send_tick(FUNC_TICK, 8'h00, 1'b0);
        send_tick(FUNC_SPARE, 8'hFF, 1'b1);
        run_op(FUNC_XFER, 8'h00, LN_LOW, FUNC_RESET);
        run_op(FUNC_XFER, 8'hFF, LN_HIGH, FUNC_XFER);
        run_op(FUNC_XFER, 8'hA5, LN_RAND, FUNC_SPARE);
        run_op(FUNC_RESET, 8'hFF, LN_ANSWER, FUNC_XFER);
        run_op(FUNC_RESET, 8'h3C, LN_HIGH, FUNC_RESET);
        run_op(FUNC_RESET, 8'hC3, LN_LOW, FUNC_TICK);

        // Longest slot release, presence sample and wait limit, other timings short
        c = '0;
        c.slot_release_us    = 4'd15;
        c.presence_sample_us = 8'd255;
        c.wait_high_limit    = 8'd255;
        load_timing(c);
        run_op(FUNC_XFER, 8'h3C, LN_RAND, FUNC_TICK);
        run_op(FUNC_RESET, 8'h00, LN_ANSWER, FUNC_XFER);

        // Random operations over several short timing sets; last one gap-free
        for (int p = 0; p < RAND_PHASES; p++) begin
            load_timing(short_timing());
            gaps_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            start_ticks = ticks_sent;
            while (ticks_sent - start_ticks < PHASE_TICKS) begin
                if ($urandom_range(0, 39) == 0) drain_results();
                pick = $urandom_range(0, 9);
                busy = ($urandom_range(0, 2) == 0) ? FUNC_W'($urandom_range(0, 3)) : FUNC_TICK;
                mode = line_mode_t'($urandom_range(0, 3));
                if (pick < 5)
                    run_op(FUNC_XFER, 8'($urandom_range(0, 255)), mode, busy);
                else if (pick < 8)
                    run_op(FUNC_RESET, 8'($urandom_range(0, 255)), mode, busy);
                else
                    send_tick((pick == 8) ? FUNC_TICK : FUNC_SPARE,
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end

        // Let the last results out and catch any stray beat
        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("one_wire_bus_master regression: pass");
        end else begin
            $display("one_wire_bus_master regression: fail");
        end
        $finish;
    end

endmodule
